// ===== rtl/utccal_pkg.sv =====
// Package for the UTC seconds-to-calendar block: queue entry and status types,
// reciprocal constants for the constant divisions, and the month start tables.
// No dependencies; used by every module of the block except the port-level checker.
`default_nettype none

package utccal_pkg;

  // Stream widths
  localparam int unsigned IN_W  = 32;
  localparam int unsigned OUT_W = 48;

  // Seconds to days: x = seconds >> 7, days = x / 675
  localparam logic [24:0] DAY_RECIP = 25'd25451658;  // floor(2^34 / 675)
  localparam int unsigned DAY_SHIFT = 34;
  localparam logic [9:0]  DAY_DIV   = 10'd675;

  // Days to four-year periods
  localparam logic [15:0] QUAD_RECIP = 16'd45933;    // floor(2^26 / 1461)
  localparam logic [10:0] QUAD_DAYS  = 11'd1461;

  // Year boundaries inside one period (1970-style: normal, normal, leap, normal)
  localparam logic [10:0] YEAR1_DAY = 11'd365;
  localparam logic [10:0] YEAR2_DAY = 11'd730;
  localparam logic [10:0] YEAR3_DAY = 11'd1096;
  localparam logic [7:0]  FIRST_YEAR = 8'd70;

  // Weekday: (days + 4) mod 7, epoch day was a Thursday
  localparam logic [15:0] WEEK_RECIP    = 16'd37449; // floor(2^18 / 7)
  localparam logic [2:0]  WEEK_DAYS     = 3'd7;
  localparam logic [2:0]  FIRST_WEEKDAY = 3'd4;

  // Seconds of day to hours, seconds of hour to minutes
  localparam logic [10:0] HOUR_RECIP = 11'd1165;     // floor(2^22 / 3600)
  localparam logic [11:0] HOUR_SECS  = 12'd3600;
  localparam logic [6:0]  MIN_RECIP  = 7'd68;        // floor(2^12 / 60)
  localparam logic [5:0]  MIN_SECS   = 6'd60;

  // First day of year (0-based) of each month
  localparam logic [8:0] MONTH_START_NORM [12] = '{
    9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
    9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
  };
  localparam logic [8:0] MONTH_START_LEAP [12] = '{
    9'd0, 9'd31, 9'd60, 9'd91, 9'd121, 9'd152,
    9'd182, 9'd213, 9'd244, 9'd274, 9'd305, 9'd335
  };

  // Queue entry: sign flag, day count and second of day
  typedef struct packed {
    logic        neg;
    logic [14:0] days;
    logic [16:0] sod;
  } utccal_day_t;

  // Queue status seen by both sides
  typedef struct packed {
    logic full;
    logic empty;
  } utccal_fifo_stat_t;

endpackage

`default_nettype wire

// ===== rtl/utccal_front.sv =====
// Front end: accepts timestamps and splits them into day count and second of day.
// Depends on utccal_pkg; feeds utccal_fifo.
`default_nettype none

module utccal_front (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [31:0]                    in_data,
  input  utccal_pkg::utccal_fifo_stat_t  q_stat,
  output logic                           q_push,
  output utccal_pkg::utccal_day_t        q_data
);

  logic        en;
  logic        v1, v2;
  logic        neg1, neg2;
  logic [23:0] x1;
  logic [10:0] x2;
  logic [6:0]  low1, low2;
  logic [48:0] prod1;
  logic [14:0] q2;
  logic [24:0] qp2;
  logic [10:0] r_raw;
  logic [10:0] r_fix;
  logic [14:0] days;

  // Pipeline advances unless a finished item cannot enter the queue
  assign en       = !v2 || !q_stat.full;
  assign in_ready = en;
  assign q_push   = v2 && !q_stat.full;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
    end
  end

  // Stage 1: reciprocal multiply of seconds/128 by 1/675
  always_ff @(posedge clk) begin
    if (en) begin
      neg1  <= in_data[31];
      x1    <= in_data[30:7];
      low1  <= in_data[6:0];
      prod1 <= 49'(in_data[30:7]) * 49'(utccal_pkg::DAY_RECIP);
    end
  end

  // Stage 2: estimated quotient times divisor
  always_ff @(posedge clk) begin
    if (en) begin
      neg2 <= neg1;
      x2   <= x1[10:0];
      low2 <= low1;
      q2   <= prod1[48:utccal_pkg::DAY_SHIFT];
      qp2  <= 25'(prod1[48:utccal_pkg::DAY_SHIFT]) * 25'(utccal_pkg::DAY_DIV);
    end
  end

  // Correction: estimate is exact or one short; remainder fits in 11 bits
  always_comb begin
    r_raw = x2 - qp2[10:0];
    if (r_raw >= 11'(utccal_pkg::DAY_DIV)) begin
      days  = q2 + 15'd1;
      r_fix = r_raw - 11'(utccal_pkg::DAY_DIV);
    end else begin
      days  = q2;
      r_fix = r_raw;
    end
    q_data.neg  = neg2;
    q_data.days = days;
    q_data.sod  = {r_fix[9:0], low2};
  end

endmodule

`default_nettype wire

// ===== rtl/utccal_fifo.sv =====
// Four-entry queue between the front end and the calendar back end.
// Depends on utccal_pkg.
`default_nettype none

module utccal_fifo (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           push,
  input  utccal_pkg::utccal_day_t        wdata,
  input  logic                           pop,
  output utccal_pkg::utccal_day_t        rdata,
  output utccal_pkg::utccal_fifo_stat_t  stat
);

  utccal_pkg::utccal_day_t mem [4];
  logic [1:0] wr_ptr;
  logic [1:0] rd_ptr;
  logic [2:0] count;
  logic       do_push;
  logic       do_pop;

  assign stat.full  = (count == 3'd4);
  assign stat.empty = (count == 3'd0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign rdata      = mem[rd_ptr];

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 2'd0;
      rd_ptr <= 2'd0;
      count  <= 3'd0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 2'd1;
      if (do_pop)  rd_ptr <= rd_ptr + 2'd1;
      count <= count + 3'(do_push) - 3'(do_pop);
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr] <= wdata;
  end

endmodule

`default_nettype wire

// ===== rtl/utccal_back.sv =====
// Back end: turns day count and second of day into calendar fields.
// Depends on utccal_pkg; drains utccal_fifo and drives the result stream.
`default_nettype none

module utccal_back (
  input  logic                           clk,
  input  logic                           rst,
  input  utccal_pkg::utccal_fifo_stat_t  q_stat,
  input  utccal_pkg::utccal_day_t        q_data,
  output logic                           q_pop,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [47:0]                    out_data,
  output logic                           out_user
);

  logic en;
  logic v1, v2, v3, v4, v5;
  logic neg1, neg2, neg3, neg4, neg5;

  // stage 1
  logic [14:0] days1;
  logic [14:0] w1;
  logic [16:0] sod1;
  logic [30:0] pq1, pw1;
  logic [27:0] ph1;
  logic [14:0] w_in;
  // stage 2
  logic [11:0] days2;
  logic [3:0]  w2;
  logic [12:0] sod2;
  logic [4:0]  qq2;
  logic [14:0] qpq2;
  logic [12:0] qw2;
  logic [14:0] qpw2;
  logic [4:0]  qh2;
  logic [16:0] qph2;
  // stage 3
  logic [4:0]  quads3;
  logic [10:0] remd3;
  logic [2:0]  wday3;
  logic [4:0]  hour3;
  logic [11:0] rems3;
  logic [11:0] rd;
  logic [3:0]  rw;
  logic [12:0] rh;
  logic [4:0]  quads_c;
  logic [10:0] remd_c;
  logic [2:0]  wday_c;
  logic [4:0]  hour_c;
  logic [11:0] rems_c;
  // stage 4
  logic [7:0]  year4;
  logic [8:0]  yday4;
  logic        leap4;
  logic [2:0]  wday4;
  logic [4:0]  hour4;
  logic [11:0] rems4;
  logic [18:0] pm4;
  logic [1:0]  yoff_c;
  logic [8:0]  yday_c;
  logic        leap_c;
  // stage 5
  logic [7:0]  year5;
  logic [3:0]  mon5;
  logic [4:0]  mday5;
  logic [8:0]  yday5;
  logic [2:0]  wday5;
  logic [4:0]  hour5;
  logic [6:0]  rems5;
  logic [5:0]  qm5;
  logic [11:0] qpm5;
  logic [3:0]  mon_c;
  logic [8:0]  mstart_c;
  logic [4:0]  mday_c;
  // output
  logic [6:0]  rm;
  logic [5:0]  min_c;
  logic [5:0]  sec_c;

  // Whole pipeline moves when the output register is free or being taken
  assign en    = !out_valid || out_ready;
  assign q_pop = en && !q_stat.empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      v5        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1        <= !q_stat.empty;
      v2        <= v1;
      v3        <= v2;
      v4        <= v3;
      v5        <= v4;
      out_valid <= v5;
    end
  end

  // Stage 1: reciprocal multiplies for periods, weekday and hours
  assign w_in = q_data.days + 15'(utccal_pkg::FIRST_WEEKDAY);

  always_ff @(posedge clk) begin
    if (en) begin
      neg1  <= q_data.neg;
      days1 <= q_data.days;
      w1    <= w_in;
      sod1  <= q_data.sod;
      pq1   <= 31'(q_data.days) * 31'(utccal_pkg::QUAD_RECIP);
      pw1   <= 31'(w_in) * 31'(utccal_pkg::WEEK_RECIP);
      ph1   <= 28'(q_data.sod) * 28'(utccal_pkg::HOUR_RECIP);
    end
  end

  // Stage 2: estimated quotients times divisors
  always_ff @(posedge clk) begin
    if (en) begin
      neg2  <= neg1;
      days2 <= days1[11:0];
      w2    <= w1[3:0];
      sod2  <= sod1[12:0];
      qq2   <= pq1[30:26];
      qpq2  <= 15'(pq1[30:26]) * 15'(utccal_pkg::QUAD_DAYS);
      qw2   <= pw1[30:18];
      qpw2  <= 15'(pw1[30:18]) * 15'(utccal_pkg::WEEK_DAYS);
      qh2   <= ph1[26:22];
      qph2  <= 17'(ph1[26:22]) * 17'(utccal_pkg::HOUR_SECS);
    end
  end

  // Stage 3: remainders with one-step correction
  always_comb begin
    rd = days2 - qpq2[11:0];
    if (rd >= 12'(utccal_pkg::QUAD_DAYS)) begin
      quads_c = qq2 + 5'd1;
      remd_c  = 11'(rd - 12'(utccal_pkg::QUAD_DAYS));
    end else begin
      quads_c = qq2;
      remd_c  = rd[10:0];
    end
    rw = w2 - qpw2[3:0];
    if (rw >= 4'(utccal_pkg::WEEK_DAYS)) wday_c = 3'(rw - 4'(utccal_pkg::WEEK_DAYS));
    else                                 wday_c = rw[2:0];
    rh = sod2 - qph2[12:0];
    if (rh >= 13'(utccal_pkg::HOUR_SECS)) begin
      hour_c = qh2 + 5'd1;
      rems_c = 12'(rh - 13'(utccal_pkg::HOUR_SECS));
    end else begin
      hour_c = qh2;
      rems_c = rh[11:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      neg3   <= neg2;
      quads3 <= quads_c;
      remd3  <= remd_c;
      wday3  <= wday_c;
      hour3  <= hour_c;
      rems3  <= rems_c;
    end
  end

  // Stage 4: year inside the period, minute reciprocal multiply
  always_comb begin
    if (remd3 < utccal_pkg::YEAR1_DAY) begin
      yoff_c = 2'd0;
      yday_c = remd3[8:0];
      leap_c = 1'b0;
    end else if (remd3 < utccal_pkg::YEAR2_DAY) begin
      yoff_c = 2'd1;
      yday_c = 9'(remd3 - utccal_pkg::YEAR1_DAY);
      leap_c = 1'b0;
    end else if (remd3 < utccal_pkg::YEAR3_DAY) begin
      yoff_c = 2'd2;
      yday_c = 9'(remd3 - utccal_pkg::YEAR2_DAY);
      leap_c = 1'b1;
    end else begin
      yoff_c = 2'd3;
      yday_c = 9'(remd3 - utccal_pkg::YEAR3_DAY);
      leap_c = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      neg4  <= neg3;
      year4 <= {1'b0, quads3, 2'b00} + 8'(yoff_c) + utccal_pkg::FIRST_YEAR;
      yday4 <= yday_c;
      leap4 <= leap_c;
      wday4 <= wday3;
      hour4 <= hour3;
      rems4 <= rems3;
      pm4   <= 19'(rems3) * 19'(utccal_pkg::MIN_RECIP);
    end
  end

  // Stage 5: month by compare against month starts, minute estimate
  always_comb begin
    mon_c = 4'd0;
    for (int k = 1; k < 12; k++) begin
      if (leap4) begin
        if (utccal_pkg::MONTH_START_LEAP[k] <= yday4) mon_c = mon_c + 4'd1;
      end else begin
        if (utccal_pkg::MONTH_START_NORM[k] <= yday4) mon_c = mon_c + 4'd1;
      end
    end
    mstart_c = leap4 ? utccal_pkg::MONTH_START_LEAP[mon_c]
                     : utccal_pkg::MONTH_START_NORM[mon_c];
    mday_c   = 5'(yday4 - mstart_c + 9'd1);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      neg5  <= neg4;
      year5 <= year4;
      mon5  <= mon_c;
      mday5 <= mday_c;
      yday5 <= yday4;
      wday5 <= wday4;
      hour5 <= hour4;
      rems5 <= rems4[6:0];
      qm5   <= pm4[17:12];
      qpm5  <= 12'(pm4[17:12]) * 12'(utccal_pkg::MIN_SECS);
    end
  end

  // Minute correction and output register; negative input gives all zero
  always_comb begin
    rm = rems5 - qpm5[6:0];
    if (rm >= 7'(utccal_pkg::MIN_SECS)) begin
      min_c = qm5 + 6'd1;
      sec_c = 6'(rm - 7'(utccal_pkg::MIN_SECS));
    end else begin
      min_c = qm5;
      sec_c = rm[5:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_user <= !neg5;
      if (neg5) out_data <= '0;
      else      out_data <= {2'b00, sec_c, min_c, hour5, wday5, yday5, mday5, mon5, year5};
    end
  end

endmodule

`default_nettype wire

// ===== rtl/utc_seconds_to_calendar_unit.sv =====
// Top level of the UTC seconds-to-calendar converter.
// Depends on utccal_pkg, utccal_front, utccal_fifo and utccal_back.
//
// Usage:
//   s_axis carries one signed 32-bit count of seconds since 1970-01-01 UTC per
//   transfer. m_axis returns one broken-down calendar result per input, in order.
//   m_axis_tuser is 1 for a converted time and 0 for a negative count, in which
//   case all of m_axis_tdata is zero.
//   Throughput is one item per cycle while m_axis is not stalled. From the input
//   transfer to m_axis_tvalid, an item passes through the register chain: 2 front
//   stages, the queue write, then 5 back stages and the output register; the
//   input edge loads the first of them.
//   A four-entry queue sits between the front and back pipelines, so input
//   transfers keep being taken while the receiver holds m_axis_tready low,
//   until the queue and front stages fill; then s_axis_tready drops.
//   A result held on m_axis stays stable until it is taken.
//   Synchronous reset empties the pipelines and the queue; there is no other
//   state and no clearing pass.
`default_nettype none

module utc_seconds_to_calendar_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [31:0] epoch_seconds
  input  logic [31:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [7:0] year_since_1900, [11:8] month, [16:12] day_of_month,
  // [25:17] day_of_year, [28:26] weekday, [33:29] hour, [39:34] minute,
  // [45:40] second, [47:46] zero
  output logic [47:0] m_axis_tdata,
  // [0] valid_res
  output logic        m_axis_tuser
);

  utccal_pkg::utccal_day_t       push_data;
  utccal_pkg::utccal_day_t       pop_data;
  utccal_pkg::utccal_fifo_stat_t q_stat;
  logic                          push;
  logic                          pop;

  utccal_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .in_data  (s_axis_tdata),
    .q_stat   (q_stat),
    .q_push   (push),
    .q_data   (push_data)
  );

  utccal_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (push_data),
    .pop   (pop),
    .rdata (pop_data),
    .stat  (q_stat)
  );

  utccal_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_stat    (q_stat),
    .q_data    (pop_data),
    .q_pop     (pop),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata),
    .out_user  (m_axis_tuser)
  );

endmodule

`default_nettype wire

// ===== rtl/utccal_checker.sv =====
// Port-level checker for the UTC seconds-to-calendar converter, with its bind.
// Depends only on the ports of utc_seconds_to_calendar_unit.
`default_nettype none

module utccal_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [47:0] m_axis_tdata,
  input logic        m_axis_tuser
);

  // A stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // Nothing comes out right after reset
  a_reset: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid after reset");

  // Negative input gives an all-zero result
  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == 48'd0)
    else $error("invalid result carries data");

  // Converted time fields stay in range
  a_fields: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |->
      m_axis_tdata[7:0] >= 8'd70 && m_axis_tdata[7:0] <= 8'd138 &&
      m_axis_tdata[11:8] <= 4'd11 && m_axis_tdata[16:12] != 5'd0 &&
      m_axis_tdata[25:17] <= 9'd365 && m_axis_tdata[28:26] <= 3'd6 &&
      m_axis_tdata[33:29] <= 5'd23 && m_axis_tdata[39:34] <= 6'd59 &&
      m_axis_tdata[45:40] <= 6'd59 && m_axis_tdata[47:46] == 2'd0)
    else $error("calendar field out of range");

endmodule

bind utc_seconds_to_calendar_unit utccal_checker u_utccal_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
